### rtl/core/msmv_pkg.sv
// ----------------------------------------------------------------------------
// msmv_pkg
// Shared types and constants for the matrix view block.
// ----------------------------------------------------------------------------
package msmv_pkg;

  localparam int ROWS  = 4;
  localparam int COLS  = 5;
  localparam int CELLS = ROWS * COLS;
  localparam int IW    = $clog2(CELLS);
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int VW    = 12;
  localparam int OW    = 15;
  localparam int SW    = VW + $clog2(COLS + 1);
  localparam logic [VW:0] MIN_START = 13'd5000;
  localparam logic [OW-1:0] SUM_MAX = 15'h7FFF;

  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_SORT  = 3'd1;
  localparam logic [2:0] CMD_EVEN  = 3'd2;
  localparam logic [2:0] CMD_ODD   = 3'd3;
  localparam logic [2:0] CMD_MAX   = 3'd4;
  localparam logic [2:0] CMD_MIN   = 3'd5;
  localparam logic [2:0] CMD_SUMS  = 3'd6;
  localparam logic [2:0] CMD_RSVD  = 3'd7;
  localparam logic [2:0] MODE_NONE = 3'd0;

  typedef enum logic [2:0] {
    VIEW_PLAIN = 3'd0,
    VIEW_EVEN  = 3'd1,
    VIEW_ODD   = 3'd2,
    VIEW_MAX   = 3'd3,
    VIEW_MIN   = 3'd4,
    VIEW_SUMS  = 3'd5
  } view_t;

  // controller -> datapath
  typedef struct packed {
    logic          wr;        // element write from input
    logic          save;      // copy matrix to backup at ptr_i
    logic          restore;   // copy backup to matrix at ptr_i
    logic          cmp;       // sort compare/swap m[ptr_i], m[ptr_j]
    logic          scan;      // max/min scan at ptr_i
    logic          scan_init;
    logic          find_max;
    logic          emit_load; // load output register for ptr_i
    logic [IW-1:0] ptr_i;
    logic [IW-1:0] ptr_j;
    view_t         view;
    logic          out_last;
  } msmv_cmd_t;

endpackage

### rtl/core/msmv_ctrl.sv
// ----------------------------------------------------------------------------
// msmv_ctrl
// Sequencer: decode, backup/restore sweeps, sort passes, scan, emission.
// ----------------------------------------------------------------------------
module msmv_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           cmd,
  input  logic [4:0]           index,
  input  logic                 out_busy,
  input  logic                 out_take,
  output msmv_pkg::msmv_cmd_t  ctl
);
  import msmv_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_COPY    = 7'b0000010,
    S_SORT    = 7'b0000100,
    S_SCAN    = 7'b0001000,
    S_EMIT    = 7'b0010000,
    S_WAIT    = 7'b0100000,
    S_RESTORE = 7'b1000000
  } state_t;

  state_t        state, state_next;
  logic [2:0]    mode;
  logic [2:0]    op;
  logic [IW-1:0] pi, pj;
  logic [2:0]    req_mode;
  logic          acc;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign req_mode = (cmd == CMD_ODD) ? CMD_EVEN : cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= MODE_NONE;
      op    <= MODE_NONE;
      pi    <= '0;
      pj    <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          pi <= '0;
          pj <= '0;
          if (acc && cmd != CMD_WRITE && cmd != CMD_RSVD) begin
            op <= cmd;
            if (mode == req_mode) mode <= MODE_NONE;
            else mode <= req_mode;
          end
        end
        S_COPY, S_RESTORE, S_SCAN: begin
          pi <= (pi == IW'(CELLS - 1)) ? '0 : pi + 1'b1;
        end
        S_SORT: begin
          if (pj == IW'(CELLS - 1)) begin
            pj <= '0;
            pi <= (pi == IW'(CELLS - 1)) ? '0 : pi + 1'b1;
          end else begin
            pj <= pj + 1'b1;
          end
        end
        S_WAIT: begin
          if (!out_busy || out_take) pi <= pi + 1'b1;
        end
        default: ;
      endcase
    end
  end

  logic last_i;
  assign last_i = (pi == IW'(CELLS - 1));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc && cmd != CMD_WRITE && cmd != CMD_RSVD)
          state_next = (mode == req_mode) ? S_RESTORE : S_COPY;
      end
      S_RESTORE: if (last_i) state_next = S_EMIT;
      S_COPY: begin
        if (last_i) begin
          if (op == CMD_SORT) state_next = S_SORT;
          else if (op == CMD_MAX || op == CMD_MIN) state_next = S_SCAN;
          else state_next = S_EMIT;
        end
      end
      S_SORT: if (last_i && pj == IW'(CELLS - 1)) state_next = S_EMIT;
      S_SCAN: if (last_i) state_next = S_EMIT;
      S_EMIT: state_next = S_WAIT;
      S_WAIT: begin
        if (!out_busy || out_take) state_next = last_i ? S_IDLE : S_EMIT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  view_t vw;
  always_comb begin
    case (op)
      CMD_EVEN: vw = VIEW_EVEN;
      CMD_ODD:  vw = VIEW_ODD;
      CMD_MAX:  vw = VIEW_MAX;
      CMD_MIN:  vw = VIEW_MIN;
      CMD_SUMS: vw = VIEW_SUMS;
      default:  vw = VIEW_PLAIN;
    endcase
  end

  // emission load happens in S_WAIT once output slot frees
  always_comb begin
    ctl           = '0;
    ctl.ptr_i     = pi;
    ctl.ptr_j     = pj;
    ctl.wr        = acc && cmd == CMD_WRITE && index < 5'(CELLS);
    ctl.save      = (state == S_COPY);
    ctl.restore   = (state == S_RESTORE);
    ctl.cmp       = (state == S_SORT);
    ctl.scan      = (state == S_SCAN);
    ctl.scan_init = (state == S_COPY);
    ctl.find_max  = (op == CMD_MAX);
    ctl.emit_load = (state == S_WAIT) && (!out_busy || out_take);
    ctl.view      = (mode == MODE_NONE) ? VIEW_PLAIN : vw;
    ctl.out_last  = last_i;
  end

  assert property (@(posedge clk) disable iff (rst) ctl.emit_load |-> !ctl.save && !ctl.cmp)
    else $error("emit overlaps matrix update");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SORT) |-> (mode == CMD_SORT))
    else $error("sorting without sort mode");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RESTORE) |-> (mode == MODE_NONE))
    else $error("restore with mode set");

endmodule

### rtl/core/msmv_dp.sv
// ----------------------------------------------------------------------------
// msmv_dp
// Matrix/backup registers, sort exchange, extreme scan, view and output reg.
// ----------------------------------------------------------------------------
module msmv_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  msmv_pkg::msmv_cmd_t           ctl,
  input  logic [4:0]                    index,
  input  logic [11:0]                   value,
  input  logic                          out_take,
  output logic                          out_busy,
  output logic [msmv_pkg::OW-1:0]       out_value,
  output logic                          out_last
);
  import msmv_pkg::*;

  logic [VW-1:0] m [CELLS];
  logic [VW-1:0] b [CELLS];
  logic [VW:0]   best;
  logic [VW-1:0] mi, mj;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [SW-1:0] rsum;
  logic [OW-1:0] sel;

  assign mi  = m[ctl.ptr_i];
  assign mj  = m[ctl.ptr_j];

  // row by compare against row starts, column by subtracting the row start
  always_comb begin
    row = '0;
    for (int r = 1; r < ROWS; r++)
      if (ctl.ptr_i >= IW'(r * COLS)) row = RW'(r);
    col = CW'(ctl.ptr_i - IW'(int'(row) * COLS));
  end

  // column-0 row sum, read at the row's fixed columns
  always_comb begin
    rsum = '0;
    for (int c = 0; c < COLS; c++)
      rsum = rsum + SW'(m[IW'(int'(row) * COLS + c)]);
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) m[index[IW-1:0]] <= value;
    if (ctl.save) b[ctl.ptr_i] <= mi;
    if (ctl.restore) m[ctl.ptr_i] <= b[ctl.ptr_i];
    if (ctl.cmp && mi < mj) begin
      m[ctl.ptr_i] <= mj;
      m[ctl.ptr_j] <= mi;
    end
    if (ctl.scan_init) best <= ctl.find_max ? '0 : MIN_START;
    else if (ctl.scan) begin
      if (ctl.find_max ? ({1'b0, mi} > best) : ({1'b0, mi} < best)) best <= {1'b0, mi};
    end
  end

  always_comb begin
    case (ctl.view)
      VIEW_EVEN: sel = mi[0] ? '0 : OW'(mi);
      VIEW_ODD:  sel = mi[0] ? OW'(mi) : '0;
      VIEW_MAX, VIEW_MIN: sel = ({1'b0, mi} == best) ? OW'(mi) : '0;
      VIEW_SUMS: begin
        if (col != '0) sel = OW'(mi);
        else if (rsum > SW'(SUM_MAX)) sel = SUM_MAX;
        else sel = OW'(rsum);
      end
      default: sel = OW'(mi);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
    end else if (ctl.emit_load) begin
      out_busy <= 1'b1;
    end else if (out_take) begin
      out_busy <= 1'b0;
    end
    if (ctl.emit_load) begin
      out_value <= sel;
      out_last  <= ctl.out_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst) ctl.emit_load |=> out_busy)
    else $error("output not held after load");

endmodule

### rtl/core/matrix_sort_and_mask_views_top.sv
// ----------------------------------------------------------------------------
// matrix_sort_and_mask_views_top
// 4x5 matrix with toggled sort/mask/extreme/row-sum views.
// ----------------------------------------------------------------------------
// channel | dir | tdata                     | tlast
// s_axis  | in  | cmd[2:0] index[7:3] value[19:8] | -
// m_axis  | out | result_value[14:0]        | last
// A view takes a backup or restore sweep over all 20 cells, then for sort
// a compare/exchange of every ordered cell pair or for max/min a scan of
// all 20 cells, then emits 20 beats through the single output register.
// Reset clears the mode; matrix contents are undefined until written.
// m_axis stalls hold the sequencer; s_axis is accepted only when idle.
module matrix_sort_and_mask_views_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [23:0]            s_axis_tdata,  // cmd, index, value, pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [15:0]            m_axis_tdata,  // result_value, pad
  output logic                   m_axis_tlast
);
  import msmv_pkg::*;

  msmv_cmd_t      ctl;
  logic           busy, take;
  logic [OW-1:0]  rv;

  assign take          = busy && m_axis_tready;
  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = {1'b0, rv};

  msmv_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .cmd(s_axis_tdata[2:0]), .index(s_axis_tdata[7:3]),
    .out_busy(busy), .out_take(take), .ctl(ctl)
  );

  msmv_dp u_dp (
    .clk, .rst, .ctl(ctl),
    .index(s_axis_tdata[7:3]), .value(s_axis_tdata[19:8]),
    .out_take(take), .out_busy(busy), .out_value(rv), .out_last(m_axis_tlast)
  );

endmodule
